[hdl/clnw_pkg.sv]
// Shared types, constants and register codes for the character LCD nibble writer.
package clnw_pkg;

	localparam int ROWS_C      = 4;
	localparam int ROW_W       = 2;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int INIT_LEN    = 7;
	localparam int INIT_BEATS  = 2 * INIT_LEN;
	localparam int BEAT_W      = 4;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [1:0] FUNC_CMD  = 2'd0;
	localparam logic [1:0] FUNC_TEXT = 2'd1;
	localparam logic [1:0] FUNC_INIT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ROW0_BASE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_BASE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_BASE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW3_BASE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CMD_WAIT    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_WAIT   = 3'd6;

	localparam logic [6:0]  ROW0_BASE_RST   = 7'h00;
	localparam logic [6:0]  ROW1_BASE_RST   = 7'h40;
	localparam logic [6:0]  ROW2_BASE_RST   = 7'h14;
	localparam logic [6:0]  ROW3_BASE_RST   = 7'h54;
	localparam logic [5:0]  LINE_LENGTH_RST = 6'd20;
	localparam logic [15:0] CMD_WAIT_RST    = 16'd2000;
	localparam logic [15:0] DATA_WAIT_RST   = 16'd1;

	localparam logic RS_CMD  = 1'b0;
	localparam logic RS_DATA = 1'b1;

	typedef struct packed {
		logic [3:0][6:0] row_base;
		logic [5:0]      line_length;
		logic [15:0]     command_wait_us;
		logic [15:0]     data_wait_us;
	} cfg_t;

	typedef enum logic [1:0] {
		JOB_CMD,
		JOB_TEXT,
		JOB_INIT
	} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic       lead_addr;
		logic [7:0] addr_cmd;
		logic [7:0] data;
	} job_t;

	// power-up: 0x33, 0x32, 4-bit two-line, display on, entry mode, clear, home
	function automatic logic [7:0] init_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0:    b = 8'b0011_0011;
			3'd1:    b = 8'b0011_0010;
			3'd2:    b = 8'b0010_1000;
			3'd3:    b = 8'b0000_1111;
			3'd4:    b = 8'b0000_0100;
			3'd5:    b = 8'b0000_0001;
			3'd6:    b = 8'b0000_0010;
			default: b = 8'b0000_0000;
		endcase
		return b;
	endfunction

endpackage

[hdl/clnw_cfg_regs.sv]
// Configuration register file: row bases, line length and post-wait times.
module clnw_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [clnw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [clnw_pkg::CFG_DATA_W-1:0] cfg_data,
	output clnw_pkg::cfg_t                cfg
);
	import clnw_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_base[0]     <= ROW0_BASE_RST;
			cfg_q.row_base[1]     <= ROW1_BASE_RST;
			cfg_q.row_base[2]     <= ROW2_BASE_RST;
			cfg_q.row_base[3]     <= ROW3_BASE_RST;
			cfg_q.line_length     <= LINE_LENGTH_RST;
			cfg_q.command_wait_us <= CMD_WAIT_RST;
			cfg_q.data_wait_us    <= DATA_WAIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROW0_BASE:   cfg_q.row_base[0]     <= cfg_data[6:0];
				REG_ROW1_BASE:   cfg_q.row_base[1]     <= cfg_data[6:0];
				REG_ROW2_BASE:   cfg_q.row_base[2]     <= cfg_data[6:0];
				REG_ROW3_BASE:   cfg_q.row_base[3]     <= cfg_data[6:0];
				REG_LINE_LENGTH: cfg_q.line_length     <= cfg_data[5:0];
				REG_CMD_WAIT:    cfg_q.command_wait_us <= cfg_data;
				REG_DATA_WAIT:   cfg_q.data_wait_us    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hdl/clnw_front.sv]
// Front end: accepts items, tracks the text position and queues jobs for the beat engine.
module clnw_front #(
	parameter int ROWS = clnw_pkg::ROWS_C
) (
	input  logic           clk,
	input  logic           arst_n,
	input  clnw_pkg::cfg_t cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     func,
	input  logic [7:0]     data_byte,
	input  logic           start_of_message,
	input  logic           q_full,
	output logic           q_push,
	output clnw_pkg::job_t q_job
);
	import clnw_pkg::*;

	logic [7:0]          pos_q;
	logic                ended_q;
	logic                accept;
	logic [5:0]          len_eff;
	logic [ROWS:0][7:0]  mult;
	logic [7:0]          pos_eff;
	logic                ended_eff;
	logic [ROW_W-1:0]    row;
	logic                col_zero;
	logic                past_end;
	logic                text_emit;
	logic [7:0]          pos_nxt;
	logic                ended_nxt;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		len_eff = (cfg.line_length == 6'd0) ? 6'd1 : cfg.line_length;
		mult[0] = 8'd0;
		for (int k = 1; k <= ROWS; k++)
			mult[k] = mult[k-1] + {2'b00, len_eff};

		pos_eff   = start_of_message ? 8'd0 : pos_q;
		ended_eff = start_of_message ? 1'b0 : ended_q;

		// row = pos / len and col == 0 by comparison against row starts
		row = '0;
		for (int k = 1; k < ROWS; k++)
			if (pos_eff >= mult[k])
				row = row + ROW_W'(1);
		col_zero = 1'b0;
		for (int k = 0; k < ROWS; k++)
			if (pos_eff == mult[k])
				col_zero = 1'b1;
		past_end = (pos_eff >= mult[ROWS]);

		text_emit = !ended_eff && (data_byte != 8'd0) && !past_end;
		pos_nxt   = text_emit ? pos_eff + 8'd1 : pos_eff;
		ended_nxt = ended_eff || !text_emit;

		q_job.lead_addr = col_zero;
		q_job.addr_cmd  = {1'b1, cfg.row_base[row]};
		q_job.data      = data_byte;
		case (func)
			FUNC_CMD: begin
				q_job.kind = JOB_CMD;
				q_push     = accept;
			end
			FUNC_TEXT: begin
				q_job.kind = JOB_TEXT;
				q_push     = accept && text_emit;
			end
			FUNC_INIT: begin
				q_job.kind = JOB_INIT;
				q_push     = accept;
			end
			default: begin
				q_job.kind = JOB_CMD;
				q_push     = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 8'd0;
			ended_q <= 1'b0;
		end else if (accept && func == FUNC_TEXT) begin
			pos_q   <= pos_nxt;
			ended_q <= ended_nxt;
		end
	end

endmodule

[hdl/clnw_job_queue.sv]
// Short job queue between the front end and the beat engine.
module clnw_job_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  clnw_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output clnw_pkg::job_t head_job
);
	import clnw_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("job pushed into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("job popped from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

[hdl/clnw_back.sv]
// Beat engine: expands the head job into E-strobed nibble beats through an output register.
module clnw_back (
	input  logic           clk,
	input  logic           arst_n,
	input  clnw_pkg::cfg_t cfg,
	input  logic           q_empty,
	input  clnw_pkg::job_t head_job,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           reg_select,
	output logic [3:0]     nibble,
	output logic [15:0]    wait_us,
	output logic           last
);
	import clnw_pkg::*;

	logic [BEAT_W-1:0] beat_q;
	logic [BEAT_W-1:0] final_beat;
	logic              fire;
	logic              last_beat;
	logic [2:0]        byte_sel;
	logic [7:0]        cur_byte;
	logic              cur_rs;
	logic [15:0]       cur_wait;
	logic              out_valid_q;
	logic              rs_q;
	logic [3:0]        nibble_q;
	logic [15:0]       wait_q;
	logic              last_q;

	assign byte_sel = beat_q[3:1];
	assign fire     = !q_empty && (!out_valid_q || out_ready);

	always_comb begin
		case (head_job.kind)
			JOB_CMD: begin
				final_beat = BEAT_W'(1);
				cur_byte   = head_job.data;
				cur_rs     = RS_CMD;
				cur_wait   = cfg.command_wait_us;
			end
			JOB_TEXT: begin
				final_beat = head_job.lead_addr ? BEAT_W'(3) : BEAT_W'(1);
				if (head_job.lead_addr && byte_sel == 3'd0) begin
					cur_byte = head_job.addr_cmd;
					cur_rs   = RS_CMD;
					cur_wait = cfg.command_wait_us;
				end else begin
					cur_byte = head_job.data;
					cur_rs   = RS_DATA;
					cur_wait = cfg.data_wait_us;
				end
			end
			JOB_INIT: begin
				final_beat = BEAT_W'(INIT_BEATS - 1);
				cur_byte   = init_byte(byte_sel);
				cur_rs     = RS_CMD;
				cur_wait   = cfg.command_wait_us;
			end
			default: begin
				final_beat = BEAT_W'(1);
				cur_byte   = head_job.data;
				cur_rs     = RS_CMD;
				cur_wait   = cfg.command_wait_us;
			end
		endcase
		last_beat = (beat_q == final_beat);
	end

	assign q_pop = fire && last_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire)
				beat_q <= last_beat ? '0 : beat_q + BEAT_W'(1);
			if (fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// high nibble first with no wait, low nibble carries the byte's wait
	always_ff @(posedge clk) begin
		if (fire) begin
			rs_q     <= cur_rs;
			nibble_q <= beat_q[0] ? cur_byte[3:0] : cur_byte[7:4];
			wait_q   <= beat_q[0] ? cur_wait : 16'd0;
			last_q   <= last_beat;
		end
	end

	assign out_valid  = out_valid_q;
	assign reg_select = rs_q;
	assign nibble     = nibble_q;
	assign wait_us    = wait_q;
	assign last       = last_q;

	a_beat_range: assert property (@(posedge clk) disable iff (!arst_n)
		beat_q < BEAT_W'(INIT_BEATS)) else $error("beat index out of range");
	a_pop_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> beat_q == '0) else $error("beat index not cleared after job");
	a_last_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> last_q == $past(q_pop)) else $error("last flag disagrees with job end");

endmodule

[hdl/char_lcd_nibble_writer.sv]
// Character LCD 4-bit writer: nibble beats for commands, text with line addressing, init.
//
// Input channel (in_valid/in_ready): func 0 sends data_byte as a command, func 1 sends it
// as a character (a set-DDRAM-address command leads each row start), func 2 sends the
// power-up sequence then clear and home. Zero bytes and text past the last row are dropped
// until start_of_message. Config channel (cfg_valid/cfg_ready) is always ready; write it
// only while the block is idle.
// Each output beat is one E strobe: RS level, D7..D4, and the wait after E falls. A byte
// is two beats, high nibble first; last marks the final beat of an item.
// Timing: an item is written into a two-entry job queue; its first beat then passes
// through the output register before it goes valid. The beat engine issues one beat per
// cycle while the receiver is ready: two beats for a command, two or four for a character,
// fourteen for init; dropped items give no beats. The beat engine sets the pace.
// A stalled receiver holds the output register; the queue keeps taking items until full.
// Reset: configuration returns to its defaults, text position to row 0 column 0, queue and
// output empty.
module char_lcd_nibble_writer #(
	parameter int ROWS = clnw_pkg::ROWS_C
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      func,
	input  logic [7:0]                      data_byte,
	input  logic                            start_of_message,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            reg_select,
	output logic [3:0]                      nibble,
	output logic [15:0]                     wait_us,
	output logic                            last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [clnw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [clnw_pkg::CFG_DATA_W-1:0] cfg_data
);
	import clnw_pkg::*;

	cfg_t cfg;
	job_t push_job;
	job_t head_job;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;

	assign cfg_ready = 1'b1;

	clnw_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	clnw_front #(
		.ROWS (ROWS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.func             (func),
		.data_byte        (data_byte),
		.start_of_message (start_of_message),
		.q_full           (q_full),
		.q_push           (q_push),
		.q_job            (push_job)
	);

	clnw_job_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head_job (head_job)
	);

	clnw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.q_empty    (q_empty),
		.head_job   (head_job),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.reg_select (reg_select),
		.nibble     (nibble),
		.wait_us    (wait_us),
		.last       (last)
	);

endmodule
